FILE: hw/rtl/kli_pkg.sv
// ----------------------------------------------------------------------------
// kli_pkg
// Types, constants and widths shared by the keyframe interpolation block.
// ----------------------------------------------------------------------------
`default_nettype none

package kli_pkg;

    localparam int MAX_KEYS    = 16;
    localparam int KEY_ADDR_W  = $clog2(MAX_KEYS);
    localparam int KEY_COUNT_W = $clog2(MAX_KEYS + 1);

    localparam int POS_W   = 32;
    localparam int TIME_W  = 17;
    localparam int QTIME_W = 20;
    localparam int PROD_W  = POS_W + TIME_W;

    // two restoring steps per cycle over the 32 quotient bits
    localparam int DIV_STEPS  = 2;
    localparam int DIV_CYCLES = POS_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam logic [TIME_W-1:0] TIME_ONE = TIME_W'(65536);

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [POS_W-1:0]   key_x;
        logic signed [POS_W-1:0]   key_y;
        logic [TIME_W-1:0]         key_time;
        logic signed [POS_W-1:0]   cur_x;
        logic signed [POS_W-1:0]   cur_y;
        logic signed [QTIME_W-1:0] query_time;
    } cmd_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] delta_x;
        logic signed [POS_W-1:0] delta_y;
        logic                    found;
    } res_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [TIME_W-1:0]       t;
    } key_entry_t;

    localparam int KEY_ENTRY_W = $bits(key_entry_t);

    typedef struct packed {
        logic signed [POS_W-1:0] a;
        logic signed [POS_W-1:0] b;
        logic [TIME_W-1:0]       num;
        logic [TIME_W-1:0]       den;
    } blend_op_t;

    typedef struct packed {
        logic                    done;
        logic signed [POS_W-1:0] result;
    } blend_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kli_cmd_if.sv
// ----------------------------------------------------------------------------
// kli_cmd_if
// Request channel: valid, ready and one command item.
// ----------------------------------------------------------------------------
`default_nettype none

interface kli_cmd_if import kli_pkg::*; ();
    logic      valid;
    logic      ready;
    cmd_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/kli_res_if.sv
// ----------------------------------------------------------------------------
// kli_res_if
// Result channel: valid, ready and one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface kli_res_if import kli_pkg::*; ();
    logic      valid;
    logic      ready;
    res_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/kli_ram.sv
// ----------------------------------------------------------------------------
// kli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/kli_blend_unit.sv
// ----------------------------------------------------------------------------
// kli_blend_unit
// Shared blend datapath: a + (b - a) * num / den with one multiply and an
// iterative restoring divide, quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_blend_unit import kli_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire blend_op_t   op,
    output blend_stat_t      stat
);

    localparam logic [2:0] U_IDLE = 3'd0;
    localparam logic [2:0] U_DIFF = 3'd1;
    localparam logic [2:0] U_MUL  = 3'd2;
    localparam logic [2:0] U_DIV  = 3'd3;
    localparam logic [2:0] U_SUM  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    blend_op_t            op_reg, op_next;
    logic                 neg_reg, neg_next;
    logic [POS_W-1:0]     mag_reg, mag_next;
    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [POS_W-1:0]     quo_reg, quo_next;

    logic signed [POS_W:0] diff;
    logic [PROD_W-1:0]     prod;
    logic [TIME_W:0]       r2 [DIV_STEPS];
    logic [TIME_W-1:0]     rs [DIV_STEPS+1];
    logic [POS_W-1:0]      qs [DIV_STEPS+1];
    logic signed [POS_W:0] sum;

    assign diff = {op_reg.b[POS_W-1], op_reg.b} - {op_reg.a[POS_W-1], op_reg.a};
    assign prod = PROD_W'(mag_reg) * PROD_W'(op_reg.num);

    // two dependent compare-subtract steps per cycle
    always_comb
    begin
        rs[0] = rem_reg;
        qs[0] = quo_reg;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            r2[s] = {rs[s], qs[s][POS_W-1]};
            if (r2[s] >= {1'b0, op_reg.den})
            begin
                rs[s+1] = TIME_W'(r2[s] - {1'b0, op_reg.den});
                qs[s+1] = {qs[s][POS_W-2:0], 1'b1};
            end
            else
            begin
                rs[s+1] = r2[s][TIME_W-1:0];
                qs[s+1] = {qs[s][POS_W-2:0], 1'b0};
            end
        end
    end

    assign sum = neg_reg ? ({op_reg.a[POS_W-1], op_reg.a} - {1'b0, quo_reg})
                         : ({op_reg.a[POS_W-1], op_reg.a} + {1'b0, quo_reg});

    assign stat.done   = (state_reg == U_SUM);
    assign stat.result = sum[POS_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    state_next = U_DIFF;
                end
            end
            U_DIFF:
            begin
                neg_next   = diff[POS_W];
                mag_next   = diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
                state_next = U_MUL;
            end
            U_MUL:
            begin
                // num < den keeps the high part below den
                rem_next   = prod[PROD_W-1:POS_W];
                quo_next   = prod[POS_W-1:0];
                cnt_next   = '0;
                state_next = U_DIV;
            end
            U_DIV:
            begin
                rem_next = rs[DIV_STEPS];
                quo_next = qs[DIV_STEPS];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                begin
                    state_next = U_SUM;
                end
            end
            U_SUM:
            begin
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/keyframe_linear_interpolation.sv
// ----------------------------------------------------------------------------
// keyframe_linear_interpolation
// Key table with a sequential scan and a shared multiply/divide blend unit.
// ----------------------------------------------------------------------------
// Requests arrive on cmd (valid/ready); results leave on res (valid/ready).
// An add request appends a key (dropped when the table is full), a clear
// request empties the table, action 3 is ignored.
// Neither gives a result. A query request gives exactly one result.
// A query reads the table one key per cycle from a registered-read RAM and
// stops at the first key pair (k-1, k) whose times bracket the query time,
// or after the last key. On a match the blend unit runs twice (x, then y),
// each run going through start, difference, multiply, an iterative divide at
// two quotient bits per cycle, and a final sum.
// cmd is ready only while no query is in work; one request is handled at a
// time. The result sits in an output register, so the next request is taken
// while it waits; if res stalls, a finished query holds until the register
// frees. Reset empties the table and drops any pending result; the key
// entries themselves are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_linear_interpolation import kli_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    kli_cmd_if.sink   cmd,
    kli_res_if.source res
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_LAUNCH_X = 3'd2;
    localparam logic [2:0] S_WAIT_X   = 3'd3;
    localparam logic [2:0] S_LAUNCH_Y = 3'd4;
    localparam logic [2:0] S_WAIT_Y   = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [KEY_COUNT_W-1:0] count_reg, count_next;
    logic [KEY_COUNT_W-1:0] idx_reg, idx_next;
    logic                   out_valid_reg, out_valid_next;
    res_item_t              out_data_reg, out_data_next;
    logic                   found_reg, found_next;

    logic [TIME_W-1:0]       t_reg, t_next;
    logic signed [POS_W-1:0] cur_x_reg, cur_x_next;
    logic signed [POS_W-1:0] cur_y_reg, cur_y_next;
    key_entry_t              prev_reg, prev_next;
    logic signed [POS_W-1:0] ax_reg, ax_next, bx_reg, bx_next;
    logic signed [POS_W-1:0] ay_reg, ay_next, by_reg, by_next;
    logic [TIME_W-1:0]       num_reg, num_next, den_reg, den_next;
    logic signed [POS_W-1:0] px_reg, px_next, py_reg, py_next;

    logic                   cmd_fire;
    logic                   ram_we;
    logic [KEY_ADDR_W-1:0]  ram_raddr;
    key_entry_t             ram_wdata;
    logic [KEY_ENTRY_W-1:0] ram_rdata;
    key_entry_t             entry;
    logic [TIME_W-1:0]      t_clamped;

    blend_op_t   blend_op;
    blend_stat_t blend_stat;
    logic        blend_start;

    logic signed [POS_W:0]   diff_x, diff_y;
    logic signed [POS_W-1:0] sat_x, sat_y;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign res.valid   = out_valid_reg;
    assign res.payload = out_data_reg;

    assign ram_we    = cmd_fire && (cmd.payload.action == ACT_ADD)
                       && (count_reg < KEY_COUNT_W'(MAX_KEYS));
    assign ram_wdata = '{x: cmd.payload.key_x, y: cmd.payload.key_y,
                         t: cmd.payload.key_time};
    assign ram_raddr = (state_reg == S_SCAN) ? idx_next[KEY_ADDR_W-1:0] : '0;
    assign entry     = key_entry_t'(ram_rdata);

    kli_ram #(
        .WIDTH (KEY_ENTRY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[KEY_ADDR_W-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign blend_start = (state_reg == S_LAUNCH_X) || (state_reg == S_LAUNCH_Y);
    assign blend_op.a   = (state_reg == S_LAUNCH_X) ? ax_reg : ay_reg;
    assign blend_op.b   = (state_reg == S_LAUNCH_X) ? bx_reg : by_reg;
    assign blend_op.num = num_reg;
    assign blend_op.den = den_reg;

    kli_blend_unit u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .start (blend_start),
        .op    (blend_op),
        .stat  (blend_stat)
    );

    // clamp query time to 0..1.0
    always_comb
    begin
        if (cmd.payload.query_time[QTIME_W-1])
        begin
            t_clamped = '0;
        end
        else if (cmd.payload.query_time > QTIME_W'(TIME_ONE))
        begin
            t_clamped = TIME_ONE;
        end
        else
        begin
            t_clamped = cmd.payload.query_time[TIME_W-1:0];
        end
    end

    assign diff_x = {px_reg[POS_W-1], px_reg} - {cur_x_reg[POS_W-1], cur_x_reg};
    assign diff_y = {py_reg[POS_W-1], py_reg} - {cur_y_reg[POS_W-1], cur_y_reg};
    assign sat_x  = (diff_x[POS_W] != diff_x[POS_W-1])
                    ? {diff_x[POS_W], {(POS_W-1){~diff_x[POS_W]}}} : diff_x[POS_W-1:0];
    assign sat_y  = (diff_y[POS_W] != diff_y[POS_W-1])
                    ? {diff_y[POS_W], {(POS_W-1){~diff_y[POS_W]}}} : diff_y[POS_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        found_next     = found_reg;
        t_next         = t_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        prev_next      = prev_reg;
        ax_next        = ax_reg;
        bx_next        = bx_reg;
        ay_next        = ay_reg;
        by_next        = by_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        px_next        = px_reg;
        py_next        = py_reg;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.payload.action)
                        ACT_ADD:
                        begin
                            if (ram_we)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_QUERY:
                        begin
                            t_next     = t_clamped;
                            cur_x_next = cmd.payload.cur_x;
                            cur_y_next = cmd.payload.cur_y;
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // entry holds key idx_reg, read in the previous cycle
                if (idx_reg >= count_reg)
                begin
                    found_next = 1'b0;
                    state_next = S_FINISH;
                end
                else if ((idx_reg != '0) && (t_reg >= prev_reg.t) && (t_reg < entry.t))
                begin
                    ax_next    = prev_reg.x;
                    bx_next    = entry.x;
                    ay_next    = prev_reg.y;
                    by_next    = entry.y;
                    num_next   = t_reg - prev_reg.t;
                    den_next   = entry.t - prev_reg.t;
                    found_next = 1'b1;
                    state_next = S_LAUNCH_X;
                end
                else
                begin
                    prev_next = entry;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            S_LAUNCH_X:
            begin
                state_next = S_WAIT_X;
            end
            S_WAIT_X:
            begin
                if (blend_stat.done)
                begin
                    px_next    = blend_stat.result;
                    state_next = S_LAUNCH_Y;
                end
            end
            S_LAUNCH_Y:
            begin
                state_next = S_WAIT_Y;
            end
            S_WAIT_Y:
            begin
                if (blend_stat.done)
                begin
                    py_next    = blend_stat.result;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next        = 1'b1;
                    out_data_next.found   = found_reg;
                    out_data_next.delta_x = found_reg ? sat_x : '0;
                    out_data_next.delta_y = found_reg ? sat_y : '0;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        t_reg        <= t_next;
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        prev_reg     <= prev_next;
        ax_reg       <= ax_next;
        bx_reg       <= bx_next;
        ay_reg       <= ay_next;
        by_reg       <= by_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= KEY_COUNT_W'(MAX_KEYS))
        else $error("key count above table depth");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        blend_stat.done |-> (state_reg == S_WAIT_X) || (state_reg == S_WAIT_Y))
        else $error("blend unit finished outside a wait state");

    a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> count_reg == $past(count_reg) + 1'b1)
        else $error("stored key not counted");

    a_query_scans: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && (cmd.payload.action == ACT_QUERY) |=> state_reg == S_SCAN)
        else $error("query request did not start a scan");

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) && out_valid_reg && !res.ready |=> state_reg == S_FINISH)
        else $error("finished query left while the output register was busy");

endmodule

`default_nettype wire

FILE: bench/kli_delta_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kli_delta_checker
// Watches both channels, keeps its own copy of the key table and predicts the
// delta and found flag of every query request. Each result leaving the block
// is compared field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module kli_delta_checker import kli_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kli_cmd_if         cmd,
    kli_res_if         res,
    output int unsigned pending,
    output int unsigned fail_count
);

    logic signed [POS_W-1:0] key_x_tbl [MAX_KEYS];
    logic signed [POS_W-1:0] key_y_tbl [MAX_KEYS];
    logic [TIME_W-1:0]       key_t_tbl [MAX_KEYS];
    int unsigned             key_total = 0;

    res_item_t   expected_deltas [$];
    res_item_t   want;
    res_item_t   got;
    cmd_item_t   req;
    int unsigned mismatches = 0;

    // a + (b - a) * num / den, quotient truncated toward zero
    function automatic longint interp_coord(input logic signed [POS_W-1:0] a,
                                            input logic signed [POS_W-1:0] b,
                                            input longint num, input longint den);
        longint diff;
        longint mag;
        longint quot;
        diff = longint'(b) - longint'(a);
        mag  = (diff < 0) ? -diff : diff;
        quot = (mag * num) / den;
        return (diff < 0) ? longint'(a) - quot : longint'(a) + quot;
    endfunction

    function automatic logic signed [POS_W-1:0] clip32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (v < -longint'(64'h8000_0000))
            return 32'sh8000_0000;
        return POS_W'(v);
    endfunction

    function automatic res_item_t predict_delta(input cmd_item_t c);
        res_item_t r;
        longint    t;
        longint    ta;
        longint    tb;
        longint    px;
        longint    py;
        int        i;
        r = '0;
        t = $signed(c.query_time);
        if (t < 0)
            t = 0;
        if (t > 65536)
            t = 65536;
        // first bracketing pair wins, pairs with tb <= ta never match
        for (i = 0; (i + 1 < key_total) && (i + 1 < MAX_KEYS) && !r.found; i++)
        begin
            ta = key_t_tbl[i];
            tb = key_t_tbl[i + 1];
            if (t >= ta && t < tb)
            begin
                px = interp_coord(key_x_tbl[i], key_x_tbl[i + 1], t - ta, tb - ta);
                py = interp_coord(key_y_tbl[i], key_y_tbl[i + 1], t - ta, tb - ta);
                r.delta_x = clip32(px - longint'($signed(c.cur_x)));
                r.delta_y = clip32(py - longint'($signed(c.cur_y)));
                r.found   = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string what, input logic [POS_W-1:0] want_v,
                               input logic [POS_W-1:0] got_v);
        if (want_v !== got_v)
        begin
            mismatches++;
            $display("%0t %s mismatch: expected %h, actual %h",
                     $time, what, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_total = 0;
            expected_deltas.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            // results first: a result accepted here always belongs to an older query
            if (res.valid && res.ready)
            begin
                got = res.payload;
                if (expected_deltas.size() == 0)
                begin
                    mismatches++;
                    $display("%0t result with no query pending: expected none, actual %h %h %b",
                             $time, got.delta_x, got.delta_y, got.found);
                end
                else
                begin
                    want = expected_deltas.pop_front();
                    check_field("delta_x", want.delta_x, got.delta_x);
                    check_field("delta_y", want.delta_y, got.delta_y);
                    check_field("found", POS_W'(want.found), POS_W'(got.found));
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                req = cmd.payload;
                case (req.action)
                    ACT_ADD:
                    begin
                        if (key_total < MAX_KEYS)
                        begin
                            key_x_tbl[key_total] = req.key_x;
                            key_y_tbl[key_total] = req.key_y;
                            key_t_tbl[key_total] = req.key_time;
                            key_total++;
                        end
                    end
                    ACT_QUERY: expected_deltas = {expected_deltas, predict_delta(req)};
                    ACT_CLEAR: key_total = 0;
                    default: ;
                endcase
            end
            pending    <= expected_deltas.size();
            fail_count <= mismatches;
        end
    end

endmodule

FILE: bench/tb_keyframe_linear_interpolation.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyframe_linear_interpolation
// Drives add, query and clear requests into the keyframe interpolation block
// with bursty timing and a stalling receiver; a directed pass over the edge
// cases is followed by random key sequences, queries and noise.
// ----------------------------------------------------------------------------

module tb_keyframe_linear_interpolation import kli_pkg::*; ();

    localparam int          RANDOM_REQUESTS = 1550;
    localparam int          CYCLE_LIMIT     = 1_000_000;
    localparam int          LONG_STALL      = 600;
    localparam int          STALL_AT        = 400;
    localparam int          TAIL_CYCLES     = 64;
    localparam logic [1:0]  ACT_UNUSED      = 2'd3;

    localparam logic [POS_W-1:0]   MAX_POS   = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0]   MIN_POS   = 32'h8000_0000;
    localparam logic [QTIME_W-1:0] QTIME_MIN = 20'h8_0000;
    localparam logic [QTIME_W-1:0] QTIME_MAX = 20'h7_FFFF;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_e;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    kli_cmd_if cmd();
    kli_res_if res();

    int unsigned delta_pending;
    int unsigned delta_failures;

    int unsigned sent_requests = 0;
    int unsigned burst_left    = 0;
    int unsigned cycle_count   = 0;
    int unsigned stop_at;
    bit          long_stall_req = 1'b0;
    bit          stall_asked    = 1'b0;
    int          key_times [$];

    rx_mode_e    rx_mode     = RX_OPEN;
    int unsigned rx_tick     = 0;
    int unsigned stall_left  = 0;
    bit          stall_taken = 1'b0;

    keyframe_linear_interpolation uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    kli_delta_checker delta_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .res        (res),
        .pending    (delta_pending),
        .fail_count (delta_failures)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: switches at random between stall patterns
    always @(posedge clk)
    begin
        rx_tick++;
        if (rx_tick % 300 == 0)
            rx_mode = rx_mode_e'($urandom_range(0, 3));
        if (long_stall_req && !stall_taken)
        begin
            stall_taken = 1'b1;
            stall_left  = LONG_STALL;
        end
        if (stall_left != 0)
        begin
            stall_left--;
            res.ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_OPEN:  res.ready <= 1'b1;
                RX_LIGHT: res.ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: res.ready <= ($urandom_range(0, 3) == 0);
                default:  res.ready <= ((rx_tick % 5) < 2);
            endcase
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic cmd_item_t random_fields();
        cmd_item_t c;
        c.action     = 2'($urandom_range(0, 3));
        c.key_x      = $urandom;
        c.key_y      = $urandom;
        c.key_time   = TIME_W'($urandom);
        c.cur_x      = $urandom;
        c.cur_y      = $urandom;
        c.query_time = QTIME_W'($urandom);
        return c;
    endfunction

    function automatic cmd_item_t make_add(input logic [POS_W-1:0] x,
                                           input logic [POS_W-1:0] y,
                                           input logic [TIME_W-1:0] t);
        cmd_item_t c;
        c          = random_fields();
        c.action   = ACT_ADD;
        c.key_x    = x;
        c.key_y    = y;
        c.key_time = t;
        return c;
    endfunction

    function automatic cmd_item_t make_query(input logic [POS_W-1:0] cx,
                                             input logic [POS_W-1:0] cy,
                                             input logic [QTIME_W-1:0] qt);
        cmd_item_t c;
        c            = random_fields();
        c.action     = ACT_QUERY;
        c.cur_x      = cx;
        c.cur_y      = cy;
        c.query_time = qt;
        return c;
    endfunction

    function automatic cmd_item_t make_clear();
        cmd_item_t c;
        c        = random_fields();
        c.action = ACT_CLEAR;
        return c;
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 7))
            0:       return MAX_POS;
            1:       return MIN_POS;
            2, 3, 4: return POS_W'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [QTIME_W-1:0] rand_qtime();
        int qt;
        case ($urandom_range(0, 11))
            0:       qt = -int'($urandom_range(1, 524288));
            1:       qt = 65536 + int'($urandom_range(1, 458751));
            2:       qt = 65536;
            3:       qt = int'($urandom);
            4, 5:    qt = (key_times.size() != 0) ?
                          key_times[$urandom_range(0, key_times.size() - 1)] : 0;
            default: qt = int'($urandom_range(0, 65536));
        endcase
        return QTIME_W'(qt);
    endfunction

    // one request; returns at the edge where it was taken, then maybe a gap
    task automatic issue_request(input cmd_item_t c);
        int unsigned gap;
        cmd.valid   <= 1'b1;
        cmd.payload <= c;
        @(posedge clk);
        while (cmd.ready !== 1'b1)
            @(posedge clk);
        if (c.action != ACT_UNUSED)
            sent_requests++;
        if (burst_left != 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                cmd.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (delta_pending != 0)
            @(posedge clk);
    endtask

    // optionally a clear, then a run of mostly ascending keys, then queries against them
    task automatic key_sequence(input bit do_clear);
        int n;
        int t_next;
        int step;
        if (do_clear)
        begin
            issue_request(make_clear());
            key_times.delete();
        end
        if (key_times.size() > 64)
            key_times.delete();
        case ($urandom_range(0, 15))
            0:       n = $urandom_range(0, 1);
            1:       n = $urandom_range(17, 20);
            2, 3:    n = $urandom_range(7, 16);
            default: n = $urandom_range(2, 6);
        endcase
        t_next = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 20000);
        repeat (n)
        begin
            issue_request(make_add(rand_pos(), rand_pos(), TIME_W'(t_next)));
            key_times = {key_times, t_next};
            case ($urandom_range(0, 7))
                0:       step = 0;
                1:       step = -int'($urandom_range(1, 5000));
                default: step = $urandom_range(1, 25000);
            endcase
            t_next = t_next + step;
            if (t_next < 0)
                t_next = 0;
            if (t_next > 131071)
                t_next = 131071;
        end
        repeat ($urandom_range(1, 8))
            issue_request(make_query(rand_pos(), rand_pos(), rand_qtime()));
    endtask

    initial
    begin
        cmd.valid   = 1'b0;
        cmd.payload = '0;
        res.ready   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, one key, then the two extreme keys
        issue_request(make_query(MIN_POS, MAX_POS, '0));
        issue_request(make_add(MAX_POS, MIN_POS, '0));
        issue_request(make_query('0, '0, QTIME_W'(100)));
        issue_request(make_add(MIN_POS, MAX_POS, TIME_ONE));
        issue_request(make_query(MIN_POS, MAX_POS, '0));
        issue_request(make_query('0, '0, QTIME_MIN));
        issue_request(make_query('0, '0, QTIME_MAX));
        issue_request(make_query(MAX_POS, MIN_POS, QTIME_W'(65535)));
        begin
            cmd_item_t odd;
            odd        = random_fields();
            odd.action = ACT_UNUSED;
            issue_request(odd);
        end
        issue_request(make_clear());
        // full table with one step back in time and a last key past 1.0
        for (int k = 0; k < MAX_KEYS; k++)
        begin
            issue_request(make_add((k % 2) ? MIN_POS : MAX_POS, POS_W'(k) << 16,
                                   (k == 5) ? TIME_W'(1000) :
                                   (k == 15) ? TIME_W'(131071) : TIME_W'(k * 4000)));
        end
        issue_request(make_add('0, '0, '0));
        issue_request(make_query(MAX_POS, MIN_POS, QTIME_W'(62000)));
        issue_request(make_query('0, '0, QTIME_W'(2000)));
        issue_request(make_query(MIN_POS, MIN_POS, QTIME_W'(65536)));
        drain_results();

        stop_at = sent_requests + RANDOM_REQUESTS;
        while (sent_requests < stop_at)
        begin
            if (!stall_asked && sent_requests >= STALL_AT)
            begin
                // receiver holds off while queries keep coming
                long_stall_req <= 1'b1;
                stall_asked = 1'b1;
                repeat (12)
                    issue_request(make_query(rand_pos(), rand_pos(), rand_qtime()));
                drain_results();
            end
            else
            begin
                case ($urandom_range(0, 15))
                    10, 11:
                        repeat ($urandom_range(1, 6))
                            issue_request(random_fields());
                    12, 13:
                        repeat ($urandom_range(1, 6))
                            issue_request(make_query(rand_pos(), rand_pos(), rand_qtime()));
                    14:
                        drain_results();
                    15:
                        key_sequence(1'b0);
                    default:
                        key_sequence($urandom_range(0, 7) != 0);
                endcase
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (delta_failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
